// File: hw/rtl/sm3_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sm3_pkg: shared types and constants
// SM3 initial vector, round constants, queue item type and round helpers.
// ----------------------------------------------------------------------------
package sm3_pkg;

  localparam logic [31:0] T_LOW    = 32'h79cc4519;
  localparam logic [31:0] T_HIGH   = 32'h7a879d8a;
  localparam logic [7:0]  PAD_BYTE = 8'h80;
  localparam int          QUEUE_DEPTH = 4;

  localparam logic [255:0] IV = {
    32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
    32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e
  };

  typedef struct packed {
    logic [31:0] data;
    logic [2:0]  count;
    logic        last;
  } item_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] d;
    d = {x, x} << n;
    return d[63:32];
  endfunction

  function automatic logic [31:0] perm0(input logic [31:0] x);
    return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
  endfunction

  function automatic logic [31:0] perm1(input logic [31:0] x);
    return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
  endfunction

endpackage

// File: hw/rtl/sm3_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sm3_front: input queue
// Accepts message beats, clamps the byte count and queues them for the core.
// ----------------------------------------------------------------------------
module sm3_front #(
  parameter int DEPTH = sm3_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  sm3_pkg::item_t  in_item,
  output logic            q_valid,
  input  logic            q_ready,
  output sm3_pkg::item_t  q_item
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  sm3_pkg::item_t mem_r [DEPTH];
  logic [AW-1:0]  wp_r, wp_nxt, rp_r, rp_nxt;
  logic [AW:0]    cnt_r, cnt_nxt;
  logic           push, pop;
  sm3_pkg::item_t clamped;

  assign in_ready = (cnt_r != (AW+1)'(DEPTH));
  assign push = in_valid && in_ready;
  assign q_valid = cnt_r != '0;
  assign pop = q_valid && q_ready;
  assign q_item = mem_r[rp_r];

  always_comb begin
    clamped = in_item;
    if (in_item.count > 3'd4) begin
      clamped.count = 3'd4;
    end
    wp_nxt = push ? ((wp_r == AW'(DEPTH-1)) ? '0 : wp_r + 1'b1) : wp_r;
    rp_nxt = pop ? ((rp_r == AW'(DEPTH-1)) ? '0 : rp_r + 1'b1) : rp_r;
    cnt_nxt = cnt_r + (AW+1)'(push) - (AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      mem_r[wp_r] <= clamped;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= (AW+1)'(DEPTH))
    else $error("queue overflow");
  assert property (@(posedge clk) disable iff (!rst_n) (cnt_r == '0) |-> !q_valid)
    else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("count lost a push");
endmodule

// File: hw/rtl/sm3_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sm3_core: byte packer, padding, compression and digest output
// Packs one byte per cycle into the block, pausing while a block compresses,
// runs 64 rounds per full block, then drives eight digest beats through an output register.
// ----------------------------------------------------------------------------
module sm3_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  output logic            q_ready,
  input  sm3_pkg::item_t  q_item,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [31:0]     out_word,
  output logic [2:0]      out_index,
  output logic            out_last
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_BYTE = 3'd1;
  localparam logic [2:0] S_PAD  = 3'd2;
  localparam logic [2:0] S_LEN  = 3'd3;
  localparam logic [2:0] S_COMP = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]   st_r, st_nxt, ret_r, ret_nxt;
  logic [31:0]  blk_r [16];
  logic [31:0]  w_r [16];
  logic [31:0]  cv_r [8];
  logic [31:0]  r_r [8];
  logic [5:0]   fill_r, fill_nxt;
  logic [63:0]  bits_r, bits_nxt, len_r, len_nxt;
  logic [6:0]   rnd_r, rnd_nxt;
  logic [2:0]   bi_r, bi_nxt;
  logic [31:0]  word_r;
  logic [2:0]   cnt_r;
  logic         last_r;
  logic [3:0]   oi_r, oi_nxt;

  logic         wr_byte, start_comp, do_round, fin_comp, load_item;
  logic [7:0]   bval;
  logic [31:0]  a12, ss1, ss2, ff, gg, tt1, tt2, tj, wj, nw;
  logic [5:0]   j6;

  assign q_ready = (st_r == S_IDLE);
  assign load_item = q_valid && q_ready;
  assign j6 = rnd_r[5:0];

  always_comb begin
    st_nxt = st_r; ret_nxt = ret_r; fill_nxt = fill_r; bits_nxt = bits_r;
    len_nxt = len_r; rnd_nxt = rnd_r; bi_nxt = bi_r; oi_nxt = oi_r;
    wr_byte = 1'b0; start_comp = 1'b0; do_round = 1'b0; fin_comp = 1'b0;
    bval = 8'h00;
    case (st_r)
      S_IDLE: begin
        if (load_item) begin
          bi_nxt = '0;
          st_nxt = S_BYTE;
        end
      end
      S_BYTE: begin
        if (bi_r < cnt_r) begin
          wr_byte = 1'b1;
          bval = word_r[31 - 8*bi_r -: 8];
          bits_nxt = bits_r + 64'd8;
          bi_nxt = bi_r + 3'd1;
        end else if (last_r) begin
          wr_byte = 1'b1;
          bval = sm3_pkg::PAD_BYTE;
          len_nxt = bits_r;
          st_nxt = S_PAD;
        end else begin
          st_nxt = S_IDLE;
        end
      end
      S_PAD: begin
        if (fill_r == 6'd56) begin
          bi_nxt = '0;
          st_nxt = S_LEN;
        end else begin
          wr_byte = 1'b1;
        end
      end
      S_LEN: begin
        wr_byte = 1'b1;
        bval = len_r[63 - 8*bi_r -: 8];
        bi_nxt = bi_r + 3'd1;
        if (bi_r == 3'd7) begin
          oi_nxt = '0;
          st_nxt = S_OUT;
        end
      end
      S_COMP: begin
        do_round = 1'b1;
        rnd_nxt = rnd_r + 7'd1;
        if (rnd_r == 7'd63) begin
          fin_comp = 1'b1;
          st_nxt = ret_r;
        end
      end
      S_OUT: begin
        if (!out_valid || out_ready) begin
          oi_nxt = oi_r + 4'd1;
          if (oi_r == 4'd8) begin
            fill_nxt = '0;
            bits_nxt = '0;
            st_nxt = S_IDLE;
          end
        end
      end
      default: st_nxt = S_IDLE;
    endcase
    if (wr_byte) begin
      fill_nxt = fill_r + 6'd1;
      if (fill_r == 6'd63) begin
        start_comp = 1'b1;
        rnd_nxt = '0;
        ret_nxt = st_nxt;
        st_nxt = S_COMP;
      end
    end
  end

  always_comb begin
    tj = (j6 < 6'd16) ? sm3_pkg::T_LOW : sm3_pkg::T_HIGH;
    wj = w_r[j6[3:0]];
    a12 = sm3_pkg::rotl(r_r[0], 5'd12);
    ss1 = sm3_pkg::rotl(a12 + r_r[4] + sm3_pkg::rotl(tj, j6[4:0]), 5'd7);
    ss2 = ss1 ^ a12;
    if (j6 < 6'd16) begin
      ff = r_r[0] ^ r_r[1] ^ r_r[2];
      gg = r_r[4] ^ r_r[5] ^ r_r[6];
    end else begin
      ff = (r_r[0] & r_r[1]) | (r_r[0] & r_r[2]) | (r_r[1] & r_r[2]);
      gg = (r_r[4] & r_r[5]) | (~r_r[4] & r_r[6]);
    end
    tt1 = ff + r_r[3] + ss2 + (wj ^ w_r[4'(j6[3:0] + 4'd4)]);
    tt2 = gg + r_r[7] + ss1 + wj;
    nw = sm3_pkg::perm1(wj ^ w_r[4'(j6[3:0] + 4'd7)]
                        ^ sm3_pkg::rotl(w_r[4'(j6[3:0] + 4'd13)], 5'd15))
         ^ sm3_pkg::rotl(w_r[4'(j6[3:0] + 4'd3)], 5'd7) ^ w_r[4'(j6[3:0] + 4'd10)];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; ret_r <= S_IDLE; fill_r <= '0; bits_r <= '0;
      rnd_r <= '0; bi_r <= '0; oi_r <= '0; out_valid <= 1'b0;
      for (int k = 0; k < 8; k++) cv_r[k] <= sm3_pkg::IV[255 - 32*k -: 32];
    end else begin
      st_r <= st_nxt; ret_r <= ret_nxt; fill_r <= fill_nxt; bits_r <= bits_nxt;
      rnd_r <= rnd_nxt; bi_r <= bi_nxt; oi_r <= oi_nxt;
      if (fin_comp) begin
        for (int k = 0; k < 8; k++) cv_r[k] <= cv_r[k] ^ (k == 0 ? tt1 :
          k == 1 ? r_r[0] : k == 2 ? sm3_pkg::rotl(r_r[1], 5'd9) : k == 3 ? r_r[2] :
          k == 4 ? sm3_pkg::perm0(tt2) : k == 5 ? r_r[4] :
          k == 6 ? sm3_pkg::rotl(r_r[5], 5'd19) : r_r[6]);
      end
      if (st_r == S_OUT && (!out_valid || out_ready)) begin
        out_valid <= (oi_r != 4'd8);
        if (oi_r == 4'd8) begin
          for (int k = 0; k < 8; k++) cv_r[k] <= sm3_pkg::IV[255 - 32*k -: 32];
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    len_r <= len_nxt;
    if (load_item) begin
      word_r <= q_item.data; cnt_r <= q_item.count; last_r <= q_item.last;
    end
    if (wr_byte) begin
      blk_r[fill_r[5:2]][31 - 8*fill_r[1:0] -: 8] <= bval;
    end
    if (st_r == S_OUT && (!out_valid || out_ready) && oi_r != 4'd8) begin
      out_word <= cv_r[oi_r[2:0]];
      out_index <= oi_r[2:0];
      out_last <= (oi_r == 4'd7);
    end
    if (start_comp) begin
      for (int k = 0; k < 16; k++) w_r[k] <= blk_r[k];
      w_r[15][7:0] <= bval;
      for (int k = 0; k < 8; k++) r_r[k] <= cv_r[k];
    end else if (do_round) begin
      w_r[j6[3:0]] <= nw;
      r_r[3] <= r_r[2]; r_r[2] <= sm3_pkg::rotl(r_r[1], 5'd9);
      r_r[1] <= r_r[0]; r_r[0] <= tt1;
      r_r[7] <= r_r[6]; r_r[6] <= sm3_pkg::rotl(r_r[5], 5'd19);
      r_r[5] <= r_r[4]; r_r[4] <= sm3_pkg::perm0(tt2);
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) (st_r == S_COMP) |-> rnd_r < 7'd64)
    else $error("round counter overrun");
  assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> st_r == S_OUT ||
    st_r == S_IDLE || st_r == S_BYTE) else $error("digest beat outside output phase");
  assert property (@(posedge clk) disable iff (!rst_n) start_comp |-> fill_r == 6'd63)
    else $error("compression on partial block");
endmodule

// File: hw/rtl/sm3_hash_engine_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sm3_hash_engine_top: SM3 hash engine
// Channel | dir | tdata (low bit up)        | tuser / tlast
// in_     | in  | data_word[31:0],byte_count | tlast = last_word
// out_    | out | digest_word[31:0],word_idx | tlast = digest_last
// An input beat is loaded from the queue, its valid bytes are packed in order and
// the core returns to idle; each full 64-byte block passes through the single-round
// compression loop. A last beat then packs the pad and length bytes, runs one or
// two compressions and sends eight digest beats, waiting on output stalls, before
// the core returns to idle.
// A four-entry queue lets input beats arrive while the core is busy.
// Synchronous active-low reset restores the initial vector; no clearing pass.
// ----------------------------------------------------------------------------
module sm3_hash_engine_top #(
  parameter int QUEUE_DEPTH = sm3_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // data_word[31:0], byte_count[34:32], zeros
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // digest_word[31:0], word_index[34:32], zeros
  output logic        out_tlast
);
  sm3_pkg::item_t in_item, q_item;
  logic           q_valid, q_ready;
  logic [31:0]    dw;
  logic [2:0]     di;

  assign in_item.data = in_tdata[31:0];
  assign in_item.count = in_tdata[34:32];
  assign in_item.last = in_tlast;

  sm3_front #(.DEPTH(QUEUE_DEPTH)) u_front (
    .clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready), .in_item,
    .q_valid, .q_ready, .q_item
  );

  sm3_core u_core (
    .clk, .rst_n, .q_valid, .q_ready, .q_item,
    .out_valid(out_tvalid), .out_ready(out_tready),
    .out_word(dw), .out_index(di), .out_last(out_tlast)
  );

  assign out_tdata = {5'd0, di, dw};
endmodule
